/* rtl/drx_pkg.sv */
// Shared types, register codes and constants of the dirty rectangle extractor.
// Used by the top level, the result queue and the port checker.
package drx_pkg;

  localparam int unsigned PIXEL_W      = 32;
  localparam int unsigned PIX_BYTES_W  = 3;
  localparam int unsigned GAP_W        = 8;
  localparam int unsigned HEIGHT_W     = 12;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned POS_W        = 12;
  localparam int unsigned SIZE_W       = 13;
  localparam int unsigned IN_DATA_W    = 64;
  localparam int unsigned OUT_DATA_W   = 56;
  localparam int unsigned OUT_PAD_W    = OUT_DATA_W - 2 * POS_W - 2 * SIZE_W;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam logic [PIX_BYTES_W-1:0] PIX_BYTES_RST    = 3'd4;
  localparam logic [GAP_W-1:0]       GAP_LIMIT_RST    = 8'd3;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_LIMIT_RST = 12'd20;

  // Result queue: deep enough to take the two results one beat can cause.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_BYTES  = 2'd0,
    REG_GAP_LIMIT    = 2'd1,
    REG_HEIGHT_LIMIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              last_rect;
    logic              no_change;
    logic [SIZE_W-1:0] rect_height;
    logic [SIZE_W-1:0] rect_width;
    logic [POS_W-1:0]  rect_y;
    logic [POS_W-1:0]  rect_x;
  } rect_t;

  // Low bytes of a pixel that take part in the compare.
  function automatic logic [PIXEL_W-1:0] byte_mask(input logic [PIX_BYTES_W-1:0] pix_bytes);
    logic [PIXEL_W-1:0] mask;
    case (pix_bytes) inside
      3'd0, 3'd1: mask = 32'h0000_00FF;
      3'd2:       mask = 32'h0000_FFFF;
      3'd3:       mask = 32'h00FF_FFFF;
      default:    mask = 32'hFFFF_FFFF;
    endcase
    return mask;
  endfunction

endpackage

/* rtl/drx_out_fifo.sv */
// Small result queue between the line tracker and the output stream.
// Takes up to two results per cycle and hands out one per beat; uses drx_pkg.
module drx_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      push_n_i,
  input  drx_pkg::rect_t                  data0_i,
  input  drx_pkg::rect_t                  data1_i,
  input  logic                            pop_i,
  output logic                            space2_o,
  output logic                            valid_o,
  output drx_pkg::rect_t                  data_o
);

  drx_pkg::rect_t                    mem_q [drx_pkg::FIFO_DEPTH];
  logic [drx_pkg::FIFO_PTR_W-1:0]    wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [drx_pkg::FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              do_pop;

  assign wr_nxt  = wr_q + drx_pkg::FIFO_PTR_W'(1);
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_q];
  assign space2_o = (cnt_q <= drx_pkg::FIFO_CNT_W'(drx_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + drx_pkg::FIFO_PTR_W'(push_n_i);
    rd_d  = rd_q + drx_pkg::FIFO_PTR_W'(do_pop);
    cnt_d = cnt_q + drx_pkg::FIFO_CNT_W'(push_n_i) - drx_pkg::FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= data1_i;
    end
  end

endmodule

/* rtl/dirty_rectangle_extractor.sv */
// Dirty rectangle extractor: takes one (new, old) pixel pair per beat and emits the
// changed rectangles of each frame. Depends on drx_pkg and drx_out_fifo.
//
// The block takes one pixel beat in every clock cycle while s_axis_tready is high.
// Its line and rectangle state is updated in the cycle of the beat, and the results
// that a line end causes (at most two: a rectangle split off and the frame's final
// result) enter a four-entry result queue that drives the output. s_axis_tready is
// low only while that queue holds more than two results, which happens only when
// the output side stalls. A frame without any change gives one result with tuser
// (no_change) set and zero geometry; the final result of each frame carries tlast.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i;
// the user must do so only while the stream is idle; the block does not enforce it.
module dirty_rectangle_extractor #(
  parameter int unsigned MAX_WIDTH  = drx_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = drx_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [drx_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [drx_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] new_pixel, [63:32] old_pixel
  input  logic [drx_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [0] end_of_line
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [11:0] rect_x, [23:12] rect_y, [36:24] rect_width, [49:37] rect_height, zeros above
  output logic [drx_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // [0] no_change
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned LW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned SW = (CW > drx_pkg::SIZE_W) ? CW : drx_pkg::SIZE_W;
  localparam int unsigned TW = (LW > drx_pkg::SIZE_W) ? LW : drx_pkg::SIZE_W;
  localparam int unsigned GW = (LW > drx_pkg::GAP_W) ? LW : drx_pkg::GAP_W;
  localparam int unsigned HW = (LW > drx_pkg::HEIGHT_W) ? LW : drx_pkg::HEIGHT_W;

  logic [drx_pkg::PIX_BYTES_W-1:0] pix_bytes_q;
  logic [drx_pkg::GAP_W-1:0]       gap_limit_q;
  logic [drx_pkg::HEIGHT_W-1:0]    height_limit_q;

  logic [CW-1:0] col_q, col_d, line_left_q, line_left_d, line_right_q, line_right_d;
  logic [CW-1:0] rect_left_q, rect_left_d, rect_right_q, rect_right_d;
  logic [LW-1:0] line_q, line_d, rect_start_q, rect_start_d, rect_last_q, rect_last_d;
  logic          line_diff_q, line_diff_d, rect_open_q, rect_open_d;

  logic                 accept, pix_diff, line_end, split, gap_over, span_over, space2;
  logic [1:0]           push_n;
  drx_pkg::rect_t       split_rect, final_rect, fifo_d0, fifo_out;
  logic [drx_pkg::PIXEL_W-1:0] new_pix, old_pix;

  function automatic drx_pkg::rect_t make_rect(input logic [CW-1:0] left,
                                               input logic [CW-1:0] right,
                                               input logic [LW-1:0] top,
                                               input logic [LW-1:0] bottom,
                                               input logic          last);
    drx_pkg::rect_t r;
    logic [SW-1:0]  w;
    logic [TW-1:0]  h;
    w             = SW'(right) - SW'(left) + SW'(1);
    h             = TW'(bottom) - TW'(top) + TW'(1);
    r.rect_x      = drx_pkg::POS_W'(left);
    r.rect_y      = drx_pkg::POS_W'(top);
    r.rect_width  = w[drx_pkg::SIZE_W-1:0];
    r.rect_height = h[drx_pkg::SIZE_W-1:0];
    r.no_change   = 1'b0;
    r.last_rect   = last;
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_bytes_q    <= drx_pkg::PIX_BYTES_RST;
      gap_limit_q    <= drx_pkg::GAP_LIMIT_RST;
      height_limit_q <= drx_pkg::HEIGHT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        drx_pkg::REG_PIXEL_BYTES:  pix_bytes_q    <= cfg_data_i[drx_pkg::PIX_BYTES_W-1:0];
        drx_pkg::REG_GAP_LIMIT:    gap_limit_q    <= cfg_data_i[drx_pkg::GAP_W-1:0];
        drx_pkg::REG_HEIGHT_LIMIT: height_limit_q <= cfg_data_i[drx_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = space2;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign new_pix       = s_axis_tdata[drx_pkg::PIXEL_W-1:0];
  assign old_pix       = s_axis_tdata[drx_pkg::IN_DATA_W-1:drx_pkg::PIXEL_W];
  assign pix_diff      = |((new_pix ^ old_pix) & drx_pkg::byte_mask(pix_bytes_q));
  assign line_end      = s_axis_tuser | s_axis_tlast;

  // The current line never lies above the rectangle's last line, so both
  // differences are taken without sign.
  assign gap_over  = (GW'(line_q) - GW'(rect_last_q)) > GW'(gap_limit_q);
  assign span_over = (HW'(rect_last_q) - HW'(rect_start_q)) > HW'(height_limit_q);

  always_comb begin
    col_d        = col_q;
    line_d       = line_q;
    line_diff_d  = line_diff_q;
    line_left_d  = line_left_q;
    line_right_d = line_right_q;
    rect_open_d  = rect_open_q;
    rect_start_d = rect_start_q;
    rect_last_d  = rect_last_q;
    rect_left_d  = rect_left_q;
    rect_right_d = rect_right_q;
    split        = 1'b0;
    split_rect   = make_rect(rect_left_q, rect_right_q, rect_start_q, rect_last_q, 1'b0);
    final_rect   = '0;
    push_n       = 2'd0;

    if (accept) begin
      if (pix_diff) begin
        if (!line_diff_q) begin
          line_left_d = col_q;
        end
        line_diff_d  = 1'b1;
        line_right_d = col_q;
      end

      if (line_end) begin
        if (line_diff_d) begin
          if (!rect_open_q) begin
            rect_open_d  = 1'b1;
            rect_start_d = line_q;
            rect_left_d  = line_left_d;
            rect_right_d = line_right_d;
          end else if (gap_over || span_over) begin
            split        = 1'b1;
            rect_start_d = line_q;
            rect_left_d  = line_left_d;
            rect_right_d = line_right_d;
          end else begin
            if (line_left_d < rect_left_q) begin
              rect_left_d = line_left_d;
            end
            if (line_right_d > rect_right_q) begin
              rect_right_d = line_right_d;
            end
          end
          rect_last_d = line_q;
        end
        col_d        = '0;
        line_diff_d  = 1'b0;
        line_left_d  = '0;
        line_right_d = '0;
        if (line_q < LW'(MAX_HEIGHT - 1)) begin
          line_d = line_q + LW'(1);
        end

        if (s_axis_tlast) begin
          if (rect_open_d) begin
            final_rect = make_rect(rect_left_d, rect_right_d, rect_start_d, rect_last_d, 1'b1);
          end else begin
            final_rect           = '0;
            final_rect.no_change = 1'b1;
            final_rect.last_rect = 1'b1;
          end
          rect_open_d  = 1'b0;
          rect_start_d = '0;
          rect_last_d  = '0;
          rect_left_d  = '0;
          rect_right_d = '0;
          line_d       = '0;
        end
      end else if (col_q < CW'(MAX_WIDTH - 1)) begin
        col_d = col_q + CW'(1);
      end

      push_n = 2'(split) + 2'(line_end & s_axis_tlast);
    end
  end

  assign fifo_d0 = split ? split_rect : final_rect;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      line_q       <= '0;
      line_diff_q  <= 1'b0;
      line_left_q  <= '0;
      line_right_q <= '0;
      rect_open_q  <= 1'b0;
      rect_start_q <= '0;
      rect_last_q  <= '0;
      rect_left_q  <= '0;
      rect_right_q <= '0;
    end else begin
      col_q        <= col_d;
      line_q       <= line_d;
      line_diff_q  <= line_diff_d;
      line_left_q  <= line_left_d;
      line_right_q <= line_right_d;
      rect_open_q  <= rect_open_d;
      rect_start_q <= rect_start_d;
      rect_last_q  <= rect_last_d;
      rect_left_q  <= rect_left_d;
      rect_right_q <= rect_right_d;
    end
  end

  drx_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .data0_i  (fifo_d0),
    .data1_i  (final_rect),
    .pop_i    (m_axis_tready),
    .space2_o (space2),
    .valid_o  (m_axis_tvalid),
    .data_o   (fifo_out)
  );

  assign m_axis_tdata = {{drx_pkg::OUT_PAD_W{1'b0}}, fifo_out.rect_height,
                         fifo_out.rect_width, fifo_out.rect_y, fifo_out.rect_x};
  assign m_axis_tuser = fifo_out.no_change;
  assign m_axis_tlast = fifo_out.last_rect;

endmodule

/* rtl/drx_checker.sv */
// Port-level checks of the dirty rectangle extractor, bound to the top level.
// Uses drx_pkg for port widths.
module drx_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [drx_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // An unchanged frame gives exactly one result, so it must close the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("no-change result without frame end mark");

  // An unchanged frame carries no geometry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("no-change result with nonzero geometry");

  // The result queue is empty right after reset.
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result beat offered right after reset");

endmodule

bind dirty_rectangle_extractor drx_port_checker u_drx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/drx_checker.sv */
// Port checker for the dirty rectangle extractor: tracks register writes and pixel
// beats, predicts the rectangles of each frame and compares every result beat.
// Depends on drx_pkg for field widths, register codes and reset values.
module drx_checker #(
  parameter int unsigned MAX_WIDTH  = drx_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = drx_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [drx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [drx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [drx_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [drx_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tuser,
  input  logic                           m_axis_tlast,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    rects_checked_o
);

  localparam int unsigned MAX_REPORTS = 30;

  drx_pkg::rect_t expected_rects[$];
  int unsigned mismatches = 0;
  int unsigned rects_checked = 0;
  int unsigned pending_q = 0;

  // Configuration as the block holds it.
  logic [drx_pkg::PIX_BYTES_W-1:0] pix_bytes;
  logic [drx_pkg::GAP_W-1:0]       gap_lim;
  logic [drx_pkg::HEIGHT_W-1:0]    height_lim;

  // Line and rectangle tracking.
  logic [drx_pkg::POS_W-1:0] col;
  logic [drx_pkg::POS_W-1:0] line_no;
  logic                      line_dirty;
  logic [drx_pkg::POS_W-1:0] line_lo;
  logic [drx_pkg::POS_W-1:0] line_hi;
  logic                      rect_open;
  logic [drx_pkg::POS_W-1:0] rect_top;
  logic [drx_pkg::POS_W-1:0] rect_bot;
  logic [drx_pkg::POS_W-1:0] rect_lo;
  logic [drx_pkg::POS_W-1:0] rect_hi;

  assign fail_count_o    = mismatches;
  assign pending_o       = pending_q;
  assign rects_checked_o = rects_checked;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  function automatic logic [drx_pkg::PIXEL_W-1:0] compared_bits(
      input logic [drx_pkg::PIX_BYTES_W-1:0] nbytes);
    logic [drx_pkg::PIXEL_W-1:0] bits;
    case (nbytes)
      3'd0, 3'd1: bits = 32'h0000_00FF;
      3'd2:       bits = 32'h0000_FFFF;
      3'd3:       bits = 32'h00FF_FFFF;
      default:    bits = 32'hFFFF_FFFF;
    endcase
    return bits;
  endfunction

  task automatic emit_rect(input logic empty, input logic last);
    drx_pkg::rect_t r;
    if (empty) begin
      r.rect_x      = '0;
      r.rect_y      = '0;
      r.rect_width  = '0;
      r.rect_height = '0;
    end else begin
      r.rect_x      = rect_lo;
      r.rect_y      = rect_top;
      r.rect_width  = {1'b0, rect_hi} - {1'b0, rect_lo} + 13'd1;
      r.rect_height = {1'b0, rect_bot} - {1'b0, rect_top} + 13'd1;
    end
    r.no_change = empty;
    r.last_rect = last;
    expected_rects.push_back(r);
  endtask

  task automatic track_pixel(input logic [drx_pkg::PIXEL_W-1:0] np,
                             input logic [drx_pkg::PIXEL_W-1:0] op,
                             input logic eol, input logic eof);
    if (((np ^ op) & compared_bits(pix_bytes)) != '0) begin
      if (!line_dirty) begin
        line_lo    = col;
        line_dirty = 1'b1;
      end
      line_hi = col;
    end
    if (eol || eof) begin
      if (line_dirty) begin
        if (!rect_open) begin
          rect_open = 1'b1;
          rect_top  = line_no;
          rect_lo   = line_lo;
          rect_hi   = line_hi;
        end else if ((32'(line_no) - 32'(rect_bot) > 32'(gap_lim)) ||
                     (32'(rect_bot) - 32'(rect_top) > 32'(height_lim))) begin
          emit_rect(1'b0, 1'b0);
          rect_top = line_no;
          rect_lo  = line_lo;
          rect_hi  = line_hi;
        end else begin
          if (line_lo < rect_lo) rect_lo = line_lo;
          if (line_hi > rect_hi) rect_hi = line_hi;
        end
        rect_bot = line_no;
      end
      col        = '0;
      line_dirty = 1'b0;
      line_lo    = '0;
      line_hi    = '0;
      if (32'(line_no) < MAX_HEIGHT - 1) line_no = line_no + 1'b1;
      if (eof) begin
        emit_rect(!rect_open, 1'b1);
        rect_open = 1'b0;
        rect_top  = '0;
        rect_bot  = '0;
        rect_lo   = '0;
        rect_hi   = '0;
        line_no   = '0;
      end
    end else if (32'(col) < MAX_WIDTH - 1) begin
      col = col + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                rects_checked, name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drx_pkg::rect_t want;
    if (!rst_ni) begin
      expected_rects.delete();
      pix_bytes  = drx_pkg::PIX_BYTES_RST;
      gap_lim    = drx_pkg::GAP_LIMIT_RST;
      height_lim = drx_pkg::HEIGHT_LIMIT_RST;
      col        = '0;
      line_no    = '0;
      line_dirty = 1'b0;
      line_lo    = '0;
      line_hi    = '0;
      rect_open  = 1'b0;
      rect_top   = '0;
      rect_bot   = '0;
      rect_lo    = '0;
      rect_hi    = '0;
      pending_q <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          drx_pkg::REG_PIXEL_BYTES:  pix_bytes  = cfg_data_i[drx_pkg::PIX_BYTES_W-1:0];
          drx_pkg::REG_GAP_LIMIT:    gap_lim    = cfg_data_i[drx_pkg::GAP_W-1:0];
          drx_pkg::REG_HEIGHT_LIMIT: height_lim = cfg_data_i[drx_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_pixel(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rects.size() == 0) begin
          report_mismatch($sformatf("result x=%0d y=%0d came out with nothing expected",
                                    m_axis_tdata[11:0], m_axis_tdata[23:12]));
        end else begin
          want = expected_rects.pop_front();
          rects_checked++;
          check_field("rect_x", m_axis_tdata[11:0], want.rect_x);
          check_field("rect_y", m_axis_tdata[23:12], want.rect_y);
          check_field("rect_width", m_axis_tdata[36:24], want.rect_width);
          check_field("rect_height", m_axis_tdata[49:37], want.rect_height);
          check_field("padding", m_axis_tdata[drx_pkg::OUT_DATA_W-1:50], 0);
          check_field("no_change", m_axis_tuser, want.no_change);
          check_field("last_rect", m_axis_tlast, want.last_rect);
        end
      end
      pending_q <= expected_rects.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the dirty rectangle extractor: clock, reset, pixel stream and
// register stimulus, output back-pressure and the verdict. Uses drx_pkg, the block
// and drx_checker, which does all prediction and comparison.
module tb_top;

  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned PHASE_BEATS = 85;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [drx_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [drx_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [drx_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           s_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [drx_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned rects_checked;

  int unsigned beats_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned settings_used = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_active = 1'b0;

  dirty_rectangle_extractor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  drx_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .rects_checked_o (rects_checked)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: random back-pressure, a long hold on request, none while no_idle is set.
  initial begin
    int unsigned r;
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_active = 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_axis_tready <= 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 92) begin
          m_axis_tready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          m_axis_tready <= 1'b0;
          n = $urandom_range(10, 40);
        end
        repeat (n) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Every sender task is entered right after a rising edge and returns right after one.
  task automatic send_beat(input logic [31:0] np, input logic [31:0] op,
                           input logic eol, input logic eof);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {op, np};
    s_axis_tuser  <= eol;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (eof) frames_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic make_pair(input int unsigned change_pct, output logic [31:0] np,
                           output logic [31:0] op);
    np = $urandom;
    op = np;
    if ($urandom_range(0, 99) < change_pct) begin
      case ($urandom_range(0, 2))
        0: op = np ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
        1: op = $urandom;
        default: op = ~np;
      endcase
    end
  endtask

  task automatic send_frame(input int unsigned lines, input int unsigned max_cols,
                            input int unsigned dirty_pct);
    logic [31:0] np;
    logic [31:0] op;
    logic        eol;
    logic        eof;
    int unsigned cols;
    bit          dirty;
    for (int unsigned l = 0; l < lines; l++) begin
      cols  = $urandom_range(1, max_cols);
      dirty = $urandom_range(0, 99) < dirty_pct;
      for (int unsigned c = 0; c < cols; c++) begin
        make_pair(dirty ? 35 : 0, np, op);
        eol = (c == cols - 1);
        eof = eol && (l == lines - 1);
        // Now and then the frame mark alone closes the last line.
        if (eof && $urandom_range(0, 3) == 0) eol = 1'b0;
        send_beat(np, op, eol, eof);
      end
    end
  endtask

  task automatic send_noise(input int unsigned n);
    logic [31:0] np;
    logic [31:0] op;
    repeat (n) begin
      make_pair(50, np, op);
      send_beat(np, op, $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic drain();
    int unsigned waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [drx_pkg::PIX_BYTES_W-1:0] pb,
                            input logic [drx_pkg::GAP_W-1:0] gap,
                            input logic [drx_pkg::HEIGHT_W-1:0] hl);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= drx_pkg::REG_PIXEL_BYTES;
    cfg_data_i <= drx_pkg::CFG_DATA_W'(pb);
    @(posedge clk_i);
    cfg_idx_i  <= drx_pkg::REG_GAP_LIMIT;
    cfg_data_i <= drx_pkg::CFG_DATA_W'(gap);
    @(posedge clk_i);
    cfg_idx_i  <= drx_pkg::REG_HEIGHT_LIMIT;
    cfg_data_i <= drx_pkg::CFG_DATA_W'(hl);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [31:0] np;
    logic [31:0] op;
    int unsigned phase_start;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = drx_pkg::REG_PIXEL_BYTES;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset settings.
    send_beat(32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1);
    // Unchanged frame closed by the frame mark alone.
    send_beat(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1, 1'b0);
    send_beat(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
    send_beat(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
    send_beat(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0);
    send_beat(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_beat(32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0, 1'b0);
    send_beat(32'h0100_0000, 32'h0000_0000, 1'b1, 1'b0);
    repeat (3) send_beat(32'h5555_5555, 32'h5555_5555, 1'b1, 1'b0);
    // Four lines below the last changed one: the rectangle splits.
    send_beat(32'h0000_8000, 32'h0000_0000, 1'b1, 1'b0);
    send_beat(32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1);
    drain();

    // Zero pixel size compares one byte; zero limits split on every chance.
    set_config(3'd0, 8'd0, 12'd0);
    send_beat(32'h0000_FF00, 32'h0000_0000, 1'b1, 1'b0);
    send_beat(32'h0000_00FF, 32'h0000_0000, 1'b1, 1'b0);
    send_beat(32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0);
    send_beat(32'h0000_0080, 32'h0000_0000, 1'b1, 1'b0);
    send_beat(32'h0000_0010, 32'h0000_0000, 1'b0, 1'b1);

    for (int unsigned phase = 0; phase < 7; phase++) begin
      drain();
      case (phase)
        0: set_config(3'd1, 8'd1, 12'd2);
        1: set_config(3'd2, 8'd0, 12'd0);
        2: set_config(3'd3, 8'd2, 12'd5);
        // Oversized pixel size and the largest limits.
        3: set_config(3'd7, 8'd255, 12'd4095);
        4: set_config(3'd5, 8'd4, 12'd1);
        default: set_config(3'($urandom_range(0, 7)), 8'($urandom_range(0, 6)),
                            12'($urandom_range(0, 8)));
      endcase
      no_idle = (phase == 2);
      phase_start = beats_sent;
      if (phase == 4) begin
        // Hold the output off while one-line frames keep coming, so the result queue fills.
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk_i);
        repeat (40) begin
          make_pair(70, np, op);
          send_beat(np, op, 1'b1, 1'b1);
        end
      end
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 85) begin
          send_frame($urandom_range(1, 12), $urandom_range(1, 6),
                     $urandom_range(0, 4) == 0 ? 0 : $urandom_range(20, 80));
        end else begin
          send_noise($urandom_range(1, 6));
        end
      end
    end
    no_idle = 1'b0;
    drain();

    if (pending != 0) $display("%0d expected results never came out", pending);
    $display("Run covered %0d pixel beats in %0d frames under %0d register settings,",
             beats_sent, frames_sent, settings_used);
    $display("with %0d rectangle results checked and %0d mismatches.",
             rects_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
